### rtl/core/heart_rate_measurement_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heart-rate measurement parser
// Clocked on clk; the first form is held off during rst.
// ----------------------------------------------------------------------------
`ifndef HEART_RATE_MEASUREMENT_PARSER_DEFINES_SVH
`define HEART_RATE_MEASUREMENT_PARSER_DEFINES_SVH

// check a property outside reset
`define HRMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property at every edge, reset included
`define HRMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/hrmp_pkg.sv
// ----------------------------------------------------------------------------
// hrmp_pkg
// Types and constants shared by the heart-rate measurement parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrmp_pkg;

  localparam int MAX_RR = 8;
  localparam logic [3:0] RR_LIMIT_RESET = 4'd8;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_RR_LIMIT = 1'd0;

  localparam logic [1:0] KIND_RATE = 2'd0;
  localparam logic [1:0] KIND_RR = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [6:0] RR_SCALE = 7'd125;

  typedef struct packed {
    logic [7:0] data_byte;
    logic packet_last;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [15:0] rate_bpm;
    logic [17:0] rr_ms_q2;
    logic [2:0] rr_index;
  } res_t;

  typedef struct packed {
    logic has_res;
    logic res_is_rr;
    logic [15:0] value;
    logic [2:0] idx;
    logic has_end;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/heart_rate_measurement_parser.sv
// ----------------------------------------------------------------------------
// heart_rate_measurement_parser
// Byte-serial parser for heart-rate measurement notifications.
//
// Input channel: push/full; one payload byte per item, packet_last on the
// final byte. Result channel: empty/pop; kind 0 gives the rate, kind 1 an
// RR interval in ms with two fraction bits, kind 2 the end of a packet.
// Config: APB write of rr_limit at address 0 (reset value 8).
//
// Throughput: one byte per cycle while the command queue has room; results
// leave at one item per cycle while the receiver pops, so a byte giving a
// result and an end marker yields two result items, absorbed by the
// four-entry command queue. A result passes the command queue and then the
// result stage's cur register before it reaches the ports.
// Reset clears the parser to expect a flags byte and drops queued items.
// When the receiver stalls, the current item holds and the queue fills;
// full then rises and holds off new bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module heart_rate_measurement_parser (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic full,
  input  wire hrmp_pkg::in_t byte_item,
  input  wire logic pop,
  output logic empty,
  output hrmp_pkg::res_t result,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [hrmp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [3:0] rr_limit;
  logic accept;
  logic cmd_valid;
  hrmp_pkg::cmd_t cmd;
  logic q_pop;
  logic q_valid;
  hrmp_pkg::cmd_t q_data;
  logic reg_hit;

  assign pready = 1'b1;
  assign reg_hit = (paddr[2] == hrmp_pkg::REG_RR_LIMIT);
  assign prdata = reg_hit ? {28'd0, rr_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rr_limit <= hrmp_pkg::RR_LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      rr_limit <= pwdata[3:0];
    end
  end

  assign accept = push && !full;

  hrmp_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .byte_item(byte_item),
    .rr_limit(rr_limit),
    .cmd_valid(cmd_valid),
    .cmd(cmd)
  );

  hrmp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(cmd_valid),
    .wr_data(cmd),
    .full(full),
    .rd_en(q_pop),
    .rd_valid(q_valid),
    .rd_data(q_data)
  );

  hrmp_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_data),
    .q_pop(q_pop),
    .pop(pop),
    .empty(empty),
    .result(result)
  );

endmodule

`default_nettype wire

### rtl/core/hrmp_queue.sv
// ----------------------------------------------------------------------------
// hrmp_queue
// Short command queue between the byte parser and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "heart_rate_measurement_parser_defines.svh"

module hrmp_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire hrmp_pkg::cmd_t wr_data,
  output logic full,
  input  wire logic rd_en,
  output logic rd_valid,
  output hrmp_pkg::cmd_t rd_data
);

  hrmp_pkg::cmd_t slots [hrmp_pkg::Q_DEPTH];
  logic [hrmp_pkg::Q_AW-1:0] wr_ptr;
  logic [hrmp_pkg::Q_AW-1:0] rd_ptr;
  logic [hrmp_pkg::Q_CW-1:0] count;

  assign full = (count == hrmp_pkg::Q_CW'(hrmp_pkg::Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `HRMP_ASSERT_ALWAYS(a_no_overflow, !(wr_en && full), "queue written while full")
  `HRMP_ASSERT(a_no_underflow, !(rd_en && !rd_valid), "queue read while empty")

endmodule

`default_nettype wire

### rtl/core/hrmp_front.sv
// ----------------------------------------------------------------------------
// hrmp_front
// Byte parser: tracks the packet layout and issues result commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "heart_rate_measurement_parser_defines.svh"

module hrmp_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire hrmp_pkg::in_t byte_item,
  input  wire logic [3:0] rr_limit,
  output logic cmd_valid,
  output hrmp_pkg::cmd_t cmd
);

  localparam logic [2:0] PH_FLAGS = 3'd0;
  localparam logic [2:0] PH_RATE_LO = 3'd1;
  localparam logic [2:0] PH_RATE_HI = 3'd2;
  localparam logic [2:0] PH_EN0 = 3'd3;
  localparam logic [2:0] PH_EN1 = 3'd4;
  localparam logic [2:0] PH_RR_LO = 3'd5;
  localparam logic [2:0] PH_RR_HI = 3'd6;
  localparam logic [2:0] PH_TAIL = 3'd7;

  logic [2:0] phase, phase_next;
  logic [7:0] flag_bits, flag_bits_next;
  logic [7:0] held_low_byte, held_low_byte_next;
  logic [3:0] rr_seen, rr_seen_next;
  logic rate_sent, rate_sent_next;

  logic [3:0] limit;
  logic [2:0] after_rate;
  logic [7:0] b;

  assign b = byte_item.data_byte;
  assign limit = (rr_limit < 4'(hrmp_pkg::MAX_RR)) ? rr_limit : 4'(hrmp_pkg::MAX_RR);
  assign after_rate = flag_bits[3] ? PH_EN0 : (flag_bits[4] ? PH_RR_LO : PH_TAIL);

  always_comb begin
    phase_next = phase;
    flag_bits_next = flag_bits;
    held_low_byte_next = held_low_byte;
    rr_seen_next = rr_seen;
    rate_sent_next = rate_sent;
    cmd = '0;
    case (phase)
      PH_FLAGS: begin
        flag_bits_next = b;
        phase_next = PH_RATE_LO;
      end
      PH_RATE_LO: begin
        if (flag_bits[0]) begin
          held_low_byte_next = b;
          phase_next = PH_RATE_HI;
        end else begin
          cmd.has_res = 1'b1;
          cmd.value = {8'd0, b};
          rate_sent_next = 1'b1;
          phase_next = after_rate;
        end
      end
      PH_RATE_HI: begin
        cmd.has_res = 1'b1;
        cmd.value = {b, held_low_byte};
        rate_sent_next = 1'b1;
        phase_next = after_rate;
      end
      PH_EN0: begin
        phase_next = PH_EN1;
      end
      PH_EN1: begin
        phase_next = flag_bits[4] ? PH_RR_LO : PH_TAIL;
      end
      PH_RR_LO: begin
        held_low_byte_next = b;
        phase_next = PH_RR_HI;
      end
      PH_RR_HI: begin
        if (rr_seen < limit) begin
          cmd.has_res = 1'b1;
          cmd.res_is_rr = 1'b1;
          cmd.value = {b, held_low_byte};
          cmd.idx = rr_seen[2:0];
          rr_seen_next = rr_seen + 1'b1;
        end
        phase_next = PH_RR_LO;
      end
      default: begin
        phase_next = phase;
      end
    endcase
    if (byte_item.packet_last) begin
      cmd.has_end = rate_sent_next;
      phase_next = PH_FLAGS;
      flag_bits_next = '0;
      held_low_byte_next = '0;
      rr_seen_next = '0;
      rate_sent_next = 1'b0;
    end
  end

  assign cmd_valid = accept && (cmd.has_res || cmd.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLAGS;
      flag_bits <= '0;
      held_low_byte <= '0;
      rr_seen <= '0;
      rate_sent <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      flag_bits <= flag_bits_next;
      held_low_byte <= held_low_byte_next;
      rr_seen <= rr_seen_next;
      rate_sent <= rate_sent_next;
    end
  end

  `HRMP_ASSERT(a_rr_bound, rr_seen <= 4'(hrmp_pkg::MAX_RR), "RR count past its bound")
  `HRMP_ASSERT(a_end_after_rate,
    cmd_valid && cmd.has_end |-> rate_sent || (cmd.has_res && !cmd.res_is_rr),
    "end marker issued for a packet without a rate")

endmodule

`default_nettype wire

### rtl/core/hrmp_back.sv
// ----------------------------------------------------------------------------
// hrmp_back
// Result stage: expands commands into result items and scales RR values.
// ----------------------------------------------------------------------------
`default_nettype none
`include "heart_rate_measurement_parser_defines.svh"

module hrmp_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire hrmp_pkg::cmd_t q_data,
  output logic q_pop,
  input  wire logic pop,
  output logic empty,
  output hrmp_pkg::res_t result
);

  hrmp_pkg::cmd_t cur;
  logic cur_valid;
  logic res_done;
  logic show_res;
  logic cur_last;
  logic take;
  logic [22:0] prod;

  assign show_res = cur.has_res && !res_done;
  assign cur_last = show_res ? !cur.has_end : 1'b1;
  assign take = cur_valid && pop;
  assign q_pop = q_valid && (!cur_valid || (take && cur_last));
  assign empty = !cur_valid;

  assign prod = 23'(cur.value) * 23'(hrmp_pkg::RR_SCALE);

  always_comb begin
    result = '0;
    if (show_res) begin
      if (cur.res_is_rr) begin
        result.kind = hrmp_pkg::KIND_RR;
        result.rr_ms_q2 = prod[22:5];
        result.rr_index = cur.idx;
      end else begin
        result.kind = hrmp_pkg::KIND_RATE;
        result.rate_bpm = cur.value;
      end
    end else begin
      result.kind = hrmp_pkg::KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      res_done <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      res_done <= 1'b0;
    end else if (take) begin
      if (cur_last) begin
        cur_valid <= 1'b0;
        res_done <= 1'b0;
      end else begin
        res_done <= 1'b1;
      end
    end
  end

  `HRMP_ASSERT(a_cmd_nonempty, cur_valid |-> cur.has_res || cur.has_end,
    "result stage holds a command with no item")
  `HRMP_ASSERT(a_res_done_end, cur_valid && res_done |-> cur.has_end,
    "second item shown for a command without an end marker")

endmodule

`default_nettype wire
